FILE: rtl/core/selectable_integer_hash_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the selectable integer hash unit
// Concurrent assertion wrappers used by the checker file sihu_checker.
// ---------------------------------------------------------------------------
`ifndef SELECTABLE_INTEGER_HASH_UNIT_MACROS_SVH
`define SELECTABLE_INTEGER_HASH_UNIT_MACROS_SVH

// Check a property on every edge outside of reset.
`define SIHU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SIHU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sihu_pkg.sv
// ---------------------------------------------------------------------------
// sihu_pkg
// Mixer ids, chain table, mixing constants and pipeline word types.
// ---------------------------------------------------------------------------
package sihu_pkg;

  // Mixer selector carried with each word, one per chain slot
  typedef enum logic [3:0] {
    MIX_IDENT  = 4'd0,
    MIX_SHADD  = 4'd1,
    MIX_GOLD   = 4'd2,
    MIX_MURMUR = 4'd3,
    MIX_SIX    = 4'd4,
    MIX_SH32   = 4'd5,
    MIX_SHMUL  = 4'd6,
    MIX_SH64   = 4'd7,
    MIX_SH5    = 4'd8,
    MIX_SEVEN  = 4'd9,
    MIX_W6     = 4'd10,
    MIX_W5     = 4'd11,
    MIX_W4     = 4'd12,
    MIX_W3     = 4'd13
  } mix_id_t;

  localparam int unsigned CHAIN_LEN = 4;

  // Slot 0 is applied first
  typedef mix_id_t [0:CHAIN_LEN-1] sihu_ids_t;

  localparam int unsigned OP_COUNT  = 38;
  localparam logic [5:0]  OP_MURMUR = 6'd3;

  // Mixing constants
  localparam logic [31:0] K_GOLDEN = 32'd2654435761;
  localparam logic [31:0] K_SHMUL  = 32'h27d4eb2d;
  localparam logic [31:0] K_SH32   = 32'd2057;
  localparam logic [31:0] K_SEED61 = 32'd61;
  localparam logic [31:0] K_SIX0   = 32'h7ed55d16;
  localparam logic [31:0] K_SIX1   = 32'hc761c23c;
  localparam logic [31:0] K_SIX2   = 32'h165667b1;
  localparam logic [31:0] K_SIX3   = 32'hd3a2646c;
  localparam logic [31:0] K_SIX4   = 32'hfd7046c5;
  localparam logic [31:0] K_SIX5   = 32'hb55a4f09;
  localparam logic [31:0] K_DEAD   = 32'hdeadbeef;
  localparam logic [31:0] K_W5A    = 32'h479ab41d;
  localparam logic [31:0] K_W5B    = 32'he4aa10ce;
  localparam logic [31:0] K_W5C    = 32'h9942f0a6;
  localparam logic [31:0] K_W5D    = 32'h5aedd67d;
  localparam logic [31:0] K_W5E    = 32'h17bea992;

  // Mixer chain for each opcode; unused slots hold the identity
  localparam sihu_ids_t CHAIN_TAB [OP_COUNT] = '{
    '{MIX_IDENT,  MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SHADD,  MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_GOLD,   MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_MURMUR, MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SIX,    MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SH32,   MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SHMUL,  MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SH64,   MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SH5,    MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_SEVEN,  MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_W6,     MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_W5,     MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_W4,     MIX_IDENT, MIX_IDENT, MIX_IDENT},
    '{MIX_W3,     MIX_IDENT, MIX_IDENT, MIX_IDENT},
    // three-stage chains
    '{MIX_SIX,    MIX_SH64,  MIX_GOLD,  MIX_IDENT},
    '{MIX_SH5,    MIX_W5,    MIX_SIX,   MIX_IDENT},
    '{MIX_W3,     MIX_SHMUL, MIX_SHADD, MIX_IDENT},
    '{MIX_W5,     MIX_SH32,  MIX_W6,    MIX_IDENT},
    '{MIX_GOLD,   MIX_SH32,  MIX_SH64,  MIX_IDENT},
    '{MIX_W6,     MIX_SHADD, MIX_SH5,   MIX_IDENT},
    '{MIX_SEVEN,  MIX_SIX,   MIX_W4,    MIX_IDENT},
    '{MIX_SH64,   MIX_W6,    MIX_W3,    MIX_IDENT},
    '{MIX_SHADD,  MIX_W3,    MIX_SH32,  MIX_IDENT},
    '{MIX_SHMUL,  MIX_W4,    MIX_SHMUL, MIX_IDENT},
    '{MIX_W4,     MIX_SH5,   MIX_SEVEN, MIX_IDENT},
    '{MIX_SH32,   MIX_SIX,   MIX_W5,    MIX_IDENT},
    // four-stage chains
    '{MIX_W4,     MIX_W3,    MIX_W5,    MIX_W6},
    '{MIX_W6,     MIX_W5,    MIX_SHADD, MIX_SHMUL},
    '{MIX_SH32,   MIX_SIX,   MIX_SEVEN, MIX_SH64},
    '{MIX_SH5,    MIX_SHMUL, MIX_GOLD,  MIX_GOLD},
    '{MIX_SHMUL,  MIX_SH64,  MIX_W4,    MIX_SIX},
    '{MIX_W3,     MIX_W4,    MIX_SH32,  MIX_SHADD},
    '{MIX_SH64,   MIX_SH5,   MIX_SH64,  MIX_SH32},
    '{MIX_W6,     MIX_SHMUL, MIX_SH5,   MIX_SEVEN},
    '{MIX_GOLD,   MIX_SIX,   MIX_W6,    MIX_SHMUL},
    '{MIX_SHADD,  MIX_GOLD,  MIX_SIX,   MIX_W3},
    '{MIX_SIX,    MIX_SH32,  MIX_SHMUL, MIX_SH5},
    '{MIX_SEVEN,  MIX_SHADD, MIX_W3,    MIX_W4}
  };

  // Word moving down the pipeline
  typedef struct packed {
    logic [31:0] key;
    sihu_ids_t   ids;
    logic        bad;
  } sihu_word_t;

  // Forward side of a link between two stages
  typedef struct packed {
    logic       valid;
    sihu_word_t word;
  } sihu_link_t;

endpackage

FILE: rtl/core/sihu_in_if.sv
// ---------------------------------------------------------------------------
// sihu_in_if
// Key channel: operation code and key with valid/ready.
// ---------------------------------------------------------------------------
interface sihu_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  opcode;
  logic [31:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

FILE: rtl/core/sihu_out_if.sv
// ---------------------------------------------------------------------------
// sihu_out_if
// Hash channel: hash and error flag with valid/ready.
// ---------------------------------------------------------------------------
interface sihu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;
  logic        bad_opcode;

  modport source (output valid, output hash, output bad_opcode, input ready);
  modport sink (input valid, input hash, input bad_opcode, output ready);
endinterface

FILE: rtl/core/sihu_decode.sv
// ---------------------------------------------------------------------------
// sihu_decode
// Entry stage: checks the opcode and looks up its mixer chain.
// ---------------------------------------------------------------------------
module sihu_decode (
  input  logic                clk,
  input  logic                rst,
  sihu_in_if.sink             req,
  output sihu_pkg::sihu_link_t dn,
  input  logic                dn_ready
);
  import sihu_pkg::*;

  logic       valid;
  sihu_word_t word;
  sihu_word_t word_next;
  logic       bad;

  assign req.ready = !valid || dn_ready;

  // Flag murmur and out-of-range codes; they run as identity on zero
  always_comb begin
    bad = (req.opcode >= 6'(OP_COUNT)) || (req.opcode == OP_MURMUR);
    word_next.bad = bad;
    if (bad) begin
      word_next.key = '0;
      word_next.ids = '{MIX_IDENT, MIX_IDENT, MIX_IDENT, MIX_IDENT};
    end else begin
      word_next.key = req.key;
      word_next.ids = CHAIN_TAB[req.opcode];
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.ready) begin
      valid <= req.valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      word <= word_next;
    end
  end

  assign dn = '{valid: valid, word: word};

endmodule

FILE: rtl/core/sihu_mix_stage.sv
// ---------------------------------------------------------------------------
// sihu_mix_stage
// One chain slot: applies the selected mixer over two register stages
// (front half, back half) and shifts the next slot into place.
// ---------------------------------------------------------------------------
module sihu_mix_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  sihu_pkg::sihu_link_t up,
  output logic                 up_ready,
  output sihu_pkg::sihu_link_t dn,
  input  logic                 dn_ready
);
  import sihu_pkg::*;

  logic       fvalid;
  sihu_word_t fword;
  sihu_word_t fword_next;
  logic       f_ready;
  logic       bvalid;
  sihu_word_t bword;
  sihu_word_t bword_next;
  logic       b_ready;

  // First half of each mixer, up to the multiply where there is one
  function automatic logic [31:0] mix_front(mix_id_t id, logic [31:0] k);
    logic [31:0] t;
    t = k;
    case (id)
      MIX_SHADD: begin
        t = t + (t << 12); t = t ^ (t >> 22);
        t = t + (t << 4);  t = t ^ (t >> 9);
      end
      MIX_GOLD: begin
        t = t >> 3;
      end
      MIX_SIX: begin
        t = (t + K_SIX0) + (t << 12);
        t = (t ^ K_SIX1) ^ (t >> 19);
        t = (t + K_SIX2) + (t << 5);
      end
      MIX_SH32: begin
        t = ~t + (t << 15);
        t = t ^ (t >> 12);
        t = t + (t << 2);
        t = t ^ (t >> 4);
      end
      MIX_SHMUL, MIX_SH5: begin
        t = (t ^ K_SEED61) ^ (t >> 16);
        t = t + (t << 3);
        t = t ^ (t >> 4);
      end
      MIX_SH64: begin
        t = ~t + (t << 21);
        t = t ^ (t >> 24);
        t = (t + (t << 3)) + (t << 8);
      end
      MIX_SEVEN: begin
        t = t - (t << 6); t = t ^ (t >> 17);
        t = t - (t << 9); t = t ^ (t << 4);
      end
      MIX_W6: begin
        t = t + ~(t << 15); t = t ^ (t >> 10); t = t + (t << 3);
      end
      MIX_W5: begin
        t = (t + K_W5A) + (t << 8);
        t = (t ^ K_W5B) ^ (t >> 5);
      end
      MIX_W4: begin
        t = (t ^ K_DEAD) + (t << 4);
        t = t ^ (t >> 10);
      end
      MIX_W3: begin
        t = t ^ (t >> 4);
        t = (t ^ K_DEAD) + (t << 5);
      end
      default: begin
        t = k;
      end
    endcase
    return t;
  endfunction

  // Second half of each mixer
  function automatic logic [31:0] mix_back(mix_id_t id, logic [31:0] k);
    logic [31:0] t;
    t = k;
    case (id)
      MIX_SHADD: begin
        t = t + (t << 10); t = t ^ (t >> 2);
        t = t + (t << 7);  t = t ^ (t >> 12);
      end
      MIX_GOLD: begin
        t = t * K_GOLDEN;
      end
      MIX_SIX: begin
        t = (t + K_SIX3) ^ (t << 9);
        t = (t + K_SIX4) + (t << 3);
        t = (t ^ K_SIX5) ^ (t >> 16);
      end
      MIX_SH32: begin
        t = t * K_SH32;
        t = t ^ (t >> 16);
      end
      MIX_SHMUL, MIX_SH5: begin
        t = t * K_SHMUL;
        t = t ^ (t >> 15);
      end
      MIX_SH64: begin
        t = t ^ (t >> 14);
        t = (t + (t << 2)) + (t << 4);
        t = t ^ (t >> 28);
        t = t + (t << 31);
      end
      MIX_SEVEN: begin
        t = t - (t << 3); t = t ^ (t << 10); t = t ^ (t >> 15);
      end
      MIX_W6: begin
        t = t ^ (t >> 6); t = t + ~(t << 11); t = t ^ (t >> 16);
      end
      MIX_W5: begin
        t = (t + K_W5C) - (t << 14);
        t = (t ^ K_W5D) ^ (t >> 3);
        t = (t + K_W5E) + (t << 7);
      end
      MIX_W4: begin
        t = t + (t << 7);
        t = t ^ (t >> 13);
      end
      MIX_W3: begin
        t = t ^ (t >> 11);
      end
      default: begin
        t = k;
      end
    endcase
    return t;
  endfunction

  assign b_ready  = !bvalid || dn_ready;
  assign f_ready  = !fvalid || b_ready;
  assign up_ready = f_ready;

  // Front half result
  always_comb begin
    fword_next     = up.word;
    fword_next.key = mix_front(up.word.ids[0], up.word.key);
  end

  // Back half result; move the next slot to the head
  always_comb begin
    bword_next     = fword;
    bword_next.key = mix_back(fword.ids[0], fword.key);
    bword_next.ids = '{fword.ids[1], fword.ids[2], fword.ids[3], MIX_IDENT};
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
      bvalid <= 1'b0;
    end else begin
      if (f_ready) begin
        fvalid <= up.valid;
      end
      if (b_ready) begin
        bvalid <= fvalid;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (f_ready && up.valid) begin
      fword <= fword_next;
    end
    if (b_ready && fvalid) begin
      bword <= bword_next;
    end
  end

  assign dn = '{valid: bvalid, word: bword};

endmodule

FILE: rtl/core/selectable_integer_hash_unit.sv
// ---------------------------------------------------------------------------
// selectable_integer_hash_unit
// Pipelined 32-bit integer hash with opcode-selected mixer chains.
// ---------------------------------------------------------------------------
//  channel | dir | fields               | handshake
//  req     | in  | opcode[5:0], key[31:0] | valid/ready
//  rsp     | out | hash[31:0], bad_opcode | valid/ready
//
//  One word per cycle while rsp.ready holds. Stages: one decode stage, then
//  four mixer slots of two stages each (front half, multiply/back half).
//  Every stage holds its own valid bit and takes a new word whenever it is
//  empty or its successor is taking, so bubbles close up under a stall.
//  Synchronous reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module selectable_integer_hash_unit (
  input  logic       clk,
  input  logic       rst,
  sihu_in_if.sink    req,
  sihu_out_if.source rsp
);
  import sihu_pkg::*;

  sihu_link_t link  [CHAIN_LEN+1];
  logic       ready [CHAIN_LEN+1];

  // Decode the opcode into a mixer chain
  sihu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .dn       (link[0]),
    .dn_ready (ready[0])
  );

  // Chain slots
  for (genvar s = 0; s < CHAIN_LEN; s++) begin : g_slot
    sihu_mix_stage u_mix (
      .clk      (clk),
      .rst      (rst),
      .up       (link[s]),
      .up_ready (ready[s]),
      .dn       (link[s+1]),
      .dn_ready (ready[s+1])
    );
  end

  // Drive the result channel from the last back-half register
  assign rsp.valid         = link[CHAIN_LEN].valid;
  assign rsp.hash          = link[CHAIN_LEN].word.key;
  assign rsp.bad_opcode    = link[CHAIN_LEN].word.bad;
  assign ready[CHAIN_LEN]  = rsp.ready;

endmodule

FILE: rtl/core/sihu_checker.sv
// ---------------------------------------------------------------------------
// sihu_checker
// Port-level checks of the hash unit, bound onto the top level.
// ---------------------------------------------------------------------------
`include "selectable_integer_hash_unit_macros.svh"

module sihu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_hash,
  input logic        rsp_bad_opcode
);

  `SIHU_ASSERT(a_bad_zero, clk, rst, rsp_valid && rsp_bad_opcode |-> rsp_hash == 32'd0, "bad opcode with nonzero hash")
  `SIHU_ASSERT(a_empty_ready, clk, rst, !rsp_valid |-> req_ready, "pipeline empty at output but not ready")
  `SIHU_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !rsp_valid, "result valid right after reset")
  `SIHU_ASSERT(a_hold_valid, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped under stall")
  `SIHU_ASSERT(a_hold_data, clk, rst, rsp_valid && !rsp_ready |=> $stable(rsp_hash) && $stable(rsp_bad_opcode), "result changed under stall")

endmodule

bind selectable_integer_hash_unit sihu_checker u_sihu_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hash       (rsp.hash),
  .rsp_bad_opcode (rsp.bad_opcode)
);
